@@ sv/lsab_pkg.sv @@
package lsab_pkg;

	// Field and register widths
	localparam int PIX_W = 32;
	localparam int ROW_W = 12;
	localparam int SR_W = 12;
	localparam int FH_W = 13;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CH_W = 8;

	// Frame height saturates here before it is halved.
	localparam int MAX_HEIGHT = 4096;
	localparam int MAXH_W = $clog2(MAX_HEIGHT + 1);
	localparam int FHX_W = (FH_W > MAXH_W) ? FH_W : MAXH_W;
	localparam int H_MAX = MAX_HEIGHT / 2;
	localparam int H_W = $clog2(H_MAX + 1);
	localparam int K_W = ((ROW_W > H_W) ? ROW_W : H_W) + 2;

	// Combined alpha, divider and weight widths
	localparam int A_W = 16;
	localparam int Q_W = 17;
	localparam int R_W = A_W + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int W_ONE = 1 << 16;
	localparam int W_SHIFT = 16;
	localparam int PROD_W = CH_W + Q_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int CH_MAX = 255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRIP_COLOR  = 2'd0,
		REG_STRIP_ROWS   = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] strip_color;
		logic [SR_W-1:0]  strip_rows;
		logic [FH_W-1:0]  frame_height;
	} cfg_t;

	// Per-pixel data that travels alongside the divider.
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             strip;
		logic [A_W-1:0]   a;
	} side_t;

	// floor(x / 255) for x up to 65025, without a divider.
	function automatic logic [CH_W-1:0] div255(input logic [A_W-1:0] x);
		logic [A_W:0] x1;
		logic [A_W:0] t;
		x1 = (A_W + 1)'(x) + (A_W + 1)'(1);
		t = x1 + (x1 >> 8);
		return t[A_W-1:8];
	endfunction

endpackage

@@ sv/letterbox_strip_alpha_blend.sv @@
// Letterbox strip blender: for each pixel with its row number, rows within strip_rows of the
// top or bottom edge get the strip color composited over them with the "over" rule, and other
// pixels pass through with in_strip low. One pixel is accepted every clock while in_stall is low;
// each result passes through one front stage, the 17-stage restoring divider that forms the
// strip weight, three weight and mix stages and the output register.
// A two-entry output buffer absorbs a stall, and in_stall rises only once it is full.
// Configuration writes take effect at once and belong between frames.
module letterbox_strip_alpha_blend (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [lsab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsab_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lsab_pkg::PIX_W-1:0]     pixel_in,
	input  logic [lsab_pkg::ROW_W-1:0]     row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lsab_pkg::PIX_W-1:0]     pixel_out,
	output logic                           in_strip
);
	import lsab_pkg::*;

	cfg_t             cfg_q;
	logic             en;

	logic             v_s1;
	side_t            side_s1;
	logic [A_W-1:0]   p_s1;
	logic             v_div;
	side_t            side_div;
	logic [Q_W-1:0]   quo_div;
	logic             rem_nz_div;
	logic             v_mix;
	logic [PIX_W-1:0] pix_mix;
	logic             strip_mix;

	logic             out_v_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_strip_q;
	logic             skid_v_q;
	logic [PIX_W-1:0] skid_pix_q;
	logic             skid_strip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_color <= PIX_W'(32'hFF00_0000);
			cfg_q.strip_rows <= SR_W'(120);
			cfg_q.frame_height <= FH_W'(480);
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STRIP_COLOR:  cfg_q.strip_color <= cfg_data[PIX_W-1:0];
				REG_STRIP_ROWS:   cfg_q.strip_rows <= cfg_data[SR_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline moves together; it holds only while the skid entry is occupied.
	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	lsab_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid),
		.pixel_in (pixel_in),
		.row      (row),
		.cfg      (cfg_q),
		.v_s1     (v_s1),
		.side_s1  (side_s1),
		.p_s1     (p_s1)
	);

	lsab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s1),
		.side_in  (side_s1),
		.p_in     (p_s1),
		.v_out    (v_div),
		.side_out (side_div),
		.quo_out  (quo_div),
		.rem_nz   (rem_nz_div)
	);

	lsab_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.v_in        (v_div),
		.side_in     (side_div),
		.quo_in      (quo_div),
		.rem_nz      (rem_nz_div),
		.strip_color (cfg_q.strip_color),
		.v_s21       (v_mix),
		.pix_s21     (pix_mix),
		.strip_s21   (strip_mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_mix;
			end
		end else if (en && v_mix) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_pix_q <= skid_pix_q;
				out_strip_q <= skid_strip_q;
			end else begin
				out_pix_q <= pix_mix;
				out_strip_q <= strip_mix;
			end
		end else if (en && v_mix) begin
			skid_pix_q <= pix_mix;
			skid_strip_q <= strip_mix;
		end
	end

	assign out_valid = out_v_q;
	assign pixel_out = out_pix_q;
	assign in_strip = out_strip_q;

	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry occupied while output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> !skid_v_q && out_v_q)
		else $error("skid entry did not drain into the output register");

endmodule

@@ sv/lsab_front.sv @@
module lsab_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [lsab_pkg::PIX_W-1:0] pixel_in,
	input  logic [lsab_pkg::ROW_W-1:0] row,
	input  lsab_pkg::cfg_t           cfg,
	output logic                     v_s1,
	output lsab_pkg::side_t          side_s1,
	output logic [lsab_pkg::A_W-1:0] p_s1
);
	import lsab_pkg::*;

	logic [FHX_W-1:0]       fhx;
	logic [H_W-1:0]         h;
	logic signed [K_W-1:0]  diff;
	logic signed [K_W-1:0]  row_dist;
	logic signed [K_W-1:0]  k;
	logic                   strip;
	logic [CH_W-1:0]        as_c;
	logic [CH_W-1:0]        ap_c;
	logic [A_W-1:0]         p;
	logic [A_W-1:0]         a;

	always_comb begin
		fhx = FHX_W'(cfg.frame_height);
		if (fhx > FHX_W'(MAX_HEIGHT)) begin
			fhx = FHX_W'(MAX_HEIGHT);
		end
		h = H_W'(fhx >> 1);
		diff = $signed(K_W'(row)) - $signed(K_W'(h));
		row_dist = (diff < 0) ? -diff : diff;
		k = $signed(K_W'(h)) - row_dist;
		// Rows past the bottom edge give a negative distance and are blended.
		strip = (k <= $signed(K_W'(cfg.strip_rows)));

		as_c = cfg.strip_color[PIX_W-1 -: CH_W];
		ap_c = pixel_in[PIX_W-1 -: CH_W];
		p = {as_c, {CH_W{1'b0}}} - A_W'(as_c);
		// The combined alpha equals 255*As + Ap*(255-As).
		a = p + A_W'(A_W'(ap_c) * A_W'(8'd255 - as_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pix <= pixel_in;
			side_s1.strip <= strip;
			side_s1.a <= a;
			p_s1 <= p;
		end
	end

endmodule

@@ sv/lsab_div.sv @@
module lsab_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  lsab_pkg::side_t          side_in,
	input  logic [lsab_pkg::A_W-1:0] p_in,
	output logic                     v_out,
	output lsab_pkg::side_t          side_out,
	output logic [lsab_pkg::Q_W-1:0] quo_out,
	output logic                     rem_nz
);
	import lsab_pkg::*;

	// One restoring step per stage; the dividend is p shifted left by 16.
	logic [DIV_STEPS-1:0]  v_s;
	side_t                 side_s [DIV_STEPS];
	logic [R_W-1:0]        rem_s [DIV_STEPS];
	logic [Q_W-1:0]        quo_s [DIV_STEPS];

	logic [R_W-1:0]        r_pre [DIV_STEPS];
	logic [Q_W-1:0]        q_pre [DIV_STEPS];
	side_t                 s_pre [DIV_STEPS];
	logic [DIV_STEPS-1:0]  v_pre;
	logic [DIV_STEPS-1:0]  take;

	always_comb begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (i == 0) begin
				r_pre[i] = R_W'(p_in);
				q_pre[i] = '0;
				s_pre[i] = side_in;
				v_pre[i] = v_in;
			end else begin
				// The remainder stays below the divisor, so the top bit is free.
				r_pre[i] = {rem_s[i-1][R_W-2:0], 1'b0};
				q_pre[i] = quo_s[i-1];
				s_pre[i] = side_s[i-1];
				v_pre[i] = v_s[i-1];
			end
			take[i] = (r_pre[i] >= R_W'(s_pre[i].a));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= v_pre;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_STEPS; i++) begin
				side_s[i] <= s_pre[i];
				rem_s[i] <= take[i] ? (r_pre[i] - R_W'(s_pre[i].a)) : r_pre[i];
				quo_s[i] <= {q_pre[i][Q_W-2:0], take[i]};
			end
		end
	end

	assign v_out = v_s[DIV_STEPS-1];
	assign side_out = side_s[DIV_STEPS-1];
	assign quo_out = quo_s[DIV_STEPS-1];
	assign rem_nz = |rem_s[DIV_STEPS-1];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_out && (side_out.a != '0) |-> rem_s[DIV_STEPS-1] < R_W'(side_out.a))
		else $error("divider remainder not below divisor");

	a_quo_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_out && (side_out.a != '0) |-> quo_out <= Q_W'(W_ONE))
		else $error("strip weight above unity");

endmodule

@@ sv/lsab_mix.sv @@
module lsab_mix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  lsab_pkg::side_t            side_in,
	input  logic [lsab_pkg::Q_W-1:0]   quo_in,
	input  logic                       rem_nz,
	input  logic [lsab_pkg::PIX_W-1:0] strip_color,
	output logic                       v_s21,
	output logic [lsab_pkg::PIX_W-1:0] pix_s21,
	output logic                       strip_s21
);
	import lsab_pkg::*;

	logic [Q_W-1:0]   ws_s19;
	logic [Q_W-1:0]   wp_s19;
	logic [PIX_W-1:0] pix_s19;
	logic             strip_s19;
	logic             azero_s19;
	logic [CH_W-1:0]  ao_s19;
	logic             v_s19;

	logic [SUM_W-1:0] sum_s20 [3];
	logic [PIX_W-1:0] pix_s20;
	logic             strip_s20;
	logic             azero_s20;
	logic [CH_W-1:0]  ao_s20;
	logic             v_s20;

	logic [SUM_W-1:0] sum_c [3];
	logic [CH_W-1:0]  chan [3];
	logic [SUM_W-W_SHIFT-1:0] hi [3];
	logic [PIX_W-1:0] blended;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
		end else if (en) begin
			v_s19 <= v_in;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
		end
	end

	// The pixel weight is 65536 minus the ceiling of the strip weight.
	always_ff @(posedge clk) begin
		if (en) begin
			ws_s19 <= quo_in;
			wp_s19 <= Q_W'(W_ONE) - quo_in - Q_W'(rem_nz);
			pix_s19 <= side_in.pix;
			strip_s19 <= side_in.strip;
			azero_s19 <= (side_in.a == '0);
			ao_s19 <= div255(side_in.a);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = SUM_W'(PROD_W'(strip_color[c*CH_W +: CH_W]) * PROD_W'(ws_s19))
				+ SUM_W'(PROD_W'(pix_s19[c*CH_W +: CH_W]) * PROD_W'(wp_s19));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sum_s20[c] <= sum_c[c];
			end
			pix_s20 <= pix_s19;
			strip_s20 <= strip_s19;
			azero_s20 <= azero_s19;
			ao_s20 <= ao_s19;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			hi[c] = sum_s20[c][SUM_W-1:W_SHIFT];
			chan[c] = (hi[c] > (SUM_W - W_SHIFT)'(CH_MAX)) ? CH_W'(CH_MAX) : hi[c][CH_W-1:0];
		end
		blended = {ao_s20, chan[2], chan[1], chan[0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			strip_s21 <= strip_s20;
			if (!strip_s20) begin
				pix_s21 <= pix_s20;
			end else if (azero_s20) begin
				pix_s21 <= '0;
			end else begin
				pix_s21 <= blended;
			end
		end
	end

endmodule

@@ tb/sv/letterbox_strip_alpha_blend_tb.sv @@
module letterbox_strip_alpha_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsab_pkg::*;

	// Index 3 is decoded by nothing in the block; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
	} pixel_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             strip;
	} blend_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic [ROW_W-1:0]     row = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 in_strip;

	// Local copy of the block's registers, at their reset values.
	logic [PIX_W-1:0] strip_color_q = 32'hFF00_0000;
	logic [SR_W-1:0]  strip_rows_q = 12'd120;
	logic [FH_W-1:0]  frame_height_q = 13'd480;

	pixel_item_t   pixels_pending[$];
	blend_result_t blend_expected[$];
	pixel_item_t   next_item;
	blend_result_t want;

	bit gaps_on = 1'b1;
	bit hold = 1'b0;
	int failures = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	int strip_pixels = 0;
	int settings_count = 0;
	int quiet_cycles = 0;

	letterbox_strip_alpha_blend DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.row(row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.in_strip(in_strip)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic blend_result_t blend_over(input logic [PIX_W-1:0] pix,
			input logic [ROW_W-1:0] pix_row);
		longint fh, h, d, k, as, ap, a, ws, wp, c;
		blend_result_t res;
		fh = longint'(frame_height_q);
		if (fh > MAX_HEIGHT)
			fh = longint'(MAX_HEIGHT);
		h = fh / 2;
		d = longint'(pix_row) - h;
		if (d < 0)
			d = -d;
		k = h - d;
		if (k > longint'(strip_rows_q)) begin
			res.pixel = pix;
			res.strip = 1'b0;
			return res;
		end
		as = longint'(strip_color_q[31:24]);
		ap = longint'(pix[31:24]);
		a = 65025 - (255 - as) * (255 - ap);
		// Both alphas zero leaves no coverage at all: the result is transparent black.
		ws = (a != 0) ? (65536 * as * 255) / a : 0;
		wp = (a != 0) ? (65536 * ap * (255 - as)) / a : 0;
		for (int i = 0; i < 3; i++) begin
			c = (longint'(strip_color_q[8*i +: 8]) * ws + longint'(pix[8*i +: 8]) * wp) >> 16;
			res.pixel[8*i +: 8] = (c > 255) ? 8'hFF : c[7:0];
		end
		c = a / 255;
		res.pixel[31:24] = (c > 255) ? 8'hFF : c[7:0];
		res.strip = 1'b1;
		return res;
	endfunction

	task automatic note_failure(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		failures++;
	endtask

	// Driver: offers the next pending pixel once the current transaction has gone through.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = blend_over(pixel_in, row);
				blend_expected.push_back(want);
				pixels_sent++;
				if (want.strip)
					strip_pixels++;
			end
			if (!in_valid || !in_stall) begin
				if (!hold && pixels_pending.size() != 0 &&
						!(gaps_on && $urandom_range(99) < 20)) begin
					next_item = pixels_pending.pop_front();
					in_valid <= 1'b1;
					pixel_in <= next_item.pix;
					row <= next_item.row;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (blend_expected.size() == 0) begin
				note_failure($sformatf("result %h with no pixel outstanding", pixel_out));
			end else begin
				want = blend_expected.pop_front();
				if (pixel_out !== want.pixel)
					note_failure($sformatf("pixel_out expected %h got %h", want.pixel, pixel_out));
				if (in_strip !== want.strip)
					note_failure($sformatf("in_strip expected %b got %b", want.strip, in_strip));
			end
		end
		out_stall <= gaps_on && ($urandom_range(99) < 20);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_STRIP_COLOR:  strip_color_q = value;
			REG_STRIP_ROWS:   strip_rows_q = value[SR_W-1:0];
			REG_FRAME_HEIGHT: frame_height_q = value[FH_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_regs(input logic [PIX_W-1:0] color, input int rows, input int height);
		write_reg(REG_STRIP_COLOR, color);
		write_reg(REG_STRIP_ROWS, rows);
		write_reg(REG_FRAME_HEIGHT, height);
		settings_count++;
	endtask

	task automatic queue_pixel(input logic [PIX_W-1:0] pix, input int pix_row);
		pixel_item_t item;
		item.pix = pix;
		item.row = ROW_W'(pix_row);
		pixels_pending.push_back(item);
	endtask

	task automatic wait_results();
		while (in_valid || blend_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pixels_pending.size() != 0)
			@(negedge clk);
		wait_results();
	endtask

	task automatic run_random_phase(input int count, input bit pause_midway);
		logic [PIX_W-1:0] color;
		logic [PIX_W-1:0] pix;
		int rows_pick, height_pick, h, base, r;
		color = $urandom;
		case ($urandom_range(2))
			0: color[31:24] = 8'h00;
			1: color[31:24] = 8'hFF;
			default: ;
		endcase
		case ($urandom_range(3))
			0: rows_pick = 0;
			1: rows_pick = 4095;
			2: rows_pick = $urandom_range(2048);
			default: rows_pick = $urandom_range(4095);
		endcase
		case ($urandom_range(6))
			0: height_pick = 0;
			1: height_pick = 1;
			2: height_pick = 4096;
			3: height_pick = 8191;
			4: height_pick = $urandom_range(4096, 2);
			5: height_pick = $urandom_range(600, 1);
			default: height_pick = $urandom_range(8191);
		endcase
		set_regs(color, rows_pick, height_pick);
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, $urandom);
		h = ((height_pick > MAX_HEIGHT) ? MAX_HEIGHT : height_pick) / 2;
		for (int n = 0; n < count; n++) begin
			pix = $urandom;
			case ($urandom_range(3))
				0: pix[31:24] = 8'h00;
				1: pix[31:24] = 8'hFF;
				default: ;
			endcase
			// Three in ten rows land near a strip edge, where an off-by-one would show.
			case ($urandom_range(9))
				0, 1, 2, 3: r = $urandom_range(4095);
				4, 5, 6: begin
					base = $urandom_range(1) ? rows_pick : 2 * h - rows_pick;
					r = base + int'($urandom_range(2)) - 1;
				end
				default: r = $urandom_range(2 * h);
			endcase
			if (r < 0)
				r = 0;
			if (r > 4095)
				r = 4095;
			queue_pixel(pix, r);
		end
		if (pause_midway) begin
			while (pixels_pending.size() > count / 2)
				@(negedge clk);
			hold = 1'b1;
			wait_results();
			hold = 1'b0;
		end
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: half height 240, strip_rows 120, so rows 0 to 120 and from 360 up are in the strip.
		queue_pixel(32'hFFFF_FFFF, 0);
		queue_pixel(32'h0000_0000, 120);
		queue_pixel(32'h80FF_00FF, 121);
		queue_pixel(32'hFFFF_FFFF, 240);
		queue_pixel(32'h0012_3456, 359);
		queue_pixel(32'h7FAB_CDEF, 360);
		queue_pixel(32'h0000_0000, 479);
		queue_pixel(32'hFF00_00FF, 480);
		queue_pixel(32'h4080_8080, 4095);
		wait_drained();

		// Transparent strip over pixels of varied alpha, and a zero frame height.
		set_regs(32'h00FF_FFFF, 0, 0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		queue_pixel(32'h00AB_CDEF, 0);
		queue_pixel(32'hFF12_3456, 4095);
		queue_pixel(32'h7F00_FF00, 2048);
		wait_drained();

		// Frame height beyond the maximum saturates before halving.
		set_regs(32'h8012_3456, 4095, 8191);
		queue_pixel(32'h40FF_FFFF, 2048);
		queue_pixel(32'hFFFF_FFFF, 0);
		queue_pixel(32'h0000_0000, 4095);
		wait_drained();

		set_regs(32'hFFFF_FFFF, 0, 1);
		queue_pixel(32'hFFFF_FFFF, 0);
		queue_pixel(32'h0101_0101, 1);
		wait_drained();

		set_regs(32'h01FF_00FF, 2047, 4096);
		queue_pixel(32'hFE00_FF00, 0);
		queue_pixel(32'hFFFF_FFFF, 2048);
		queue_pixel(32'h8080_8080, 1);
		wait_drained();

		for (int p = 0; p < 16; p++) begin
			gaps_on = !(p >= 6 && p <= 8);
			run_random_phase(100, p == 3 || p == 11);
		end
		gaps_on = 1'b0;

		for (int c = 0; c < DRAIN_CYCLES; c++)
			@(posedge clk);
		if (blend_expected.size() != 0)
			note_failure($sformatf("%0d results never arrived", blend_expected.size()));

		$display("Sent %0d pixels (%0d inside the strip) over %0d register settings;",
			pixels_sent, strip_pixels, settings_count);
		$display("checked %0d results with random input gaps and output stalls.", results_seen);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ files.f @@
sv/lsab_pkg.sv
sv/lsab_front.sv
sv/lsab_div.sv
sv/lsab_mix.sv
sv/letterbox_strip_alpha_blend.sv
tb/sv/letterbox_strip_alpha_blend_tb.sv
